// ===== rtl/session_address_table_defines.svh =====
// session_address_table_defines.svh: assertion macros for the session table checker.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef SESSION_ADDRESS_TABLE_DEFINES_SVH
`define SESSION_ADDRESS_TABLE_DEFINES_SVH

// Implication checked in the same cycle
`define SAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sat_pkg.sv =====
// sat_pkg.sv: shared types, codes and constants of the session address table.
// No dependencies; used by all modules of the block but sat_ram.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

  // key layout: {v6, port[15:0], ip_high[63:0], ip_low[63:0]}
  localparam int KEY_W  = 145;
  // session entry: {active, key}
  localparam int SESS_W = 146;
  localparam int PACK_W = 152;

  localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_CREATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_REBIND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_UNINDEXED = 3'd4,
    ST_DONE      = 3'd5,
    ST_BAD       = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    SRD_SCAN = 2'd0,
    SRD_SLOT = 2'd1,
    SRD_TGT  = 2'd2
  } srd_sel_t;

  typedef enum logic [1:0] {
    ACT_ONE  = 2'd0,
    ACT_ZERO = 2'd1,
    ACT_KEEP = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    NUM_ZERO = 2'd0,
    NUM_SLOT = 2'd1,
    NUM_SCAN = 2'd2,
    NUM_SIDX = 2'd3
  } num_t;

  // controller to datapath
  typedef struct packed {
    logic     latch;
    logic     wk_load_in;
    logic     wk_load_sess;
    logic     hash_start;
    logic     probe_init;
    logic     slot_rd;
    logic     note_del;
    logic     advance;
    logic     sess_rd;
    srd_sel_t sess_rd_sel;
    logic     scan_init;
    logic     scan_inc;
    logic     sidx_tgt;
    logic     sidx_used;
    logic     used_inc;
    logic     sess_wr;
    act_t     act_mode;
    logic     slot_wr;
    logic     slot_wr_first;
    tag_t     slot_wr_tag;
    logic     emit;
    status_t  emit_status;
    num_t     num_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic tgt_ok;
    tag_t tag;
    logic hash_eq;
    logic sess_eq;
    logic slot_sess_ok;
    logic have_del;
    logic probe_last;
    logic scan_end;
    logic used_full;
    logic slot_last;
    logic hash_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/sat_ram.sv =====
// sat_ram.sv: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sat_hash.sv =====
// sat_hash.sv: iterative FNV-1a hash over the key bytes, then start slot by modulo.
// Depends on sat_pkg. One key byte per cycle, then four remainder bits per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sat_hash #(
  parameter int HASH_SLOTS = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sat_pkg::KEY_W-1:0]     key,
  output logic                               busy,
  output logic [31:0]                        hash,
  output logic [$clog2(HASH_SLOTS)-1:0]      slot
);

  localparam int SLW = $clog2(HASH_SLOTS);
  localparam logic [SLW:0] NSL = (SLW + 1)'(HASH_SLOTS);

  typedef enum logic [1:0] {H_IDLE, H_BYTE, H_MOD} hstate_t;

  hstate_t                     state_r;
  logic [sat_pkg::PACK_W-1:0]  sh_r;
  logic [4:0]                  cnt_r;
  logic [31:0]                 h_r;
  logic [31:0]                 mq_r;
  logic [2:0]                  mcnt_r;
  logic [SLW-1:0]              m_r;
  logic [sat_pkg::PACK_W-1:0]  pack;
  logic [31:0]                 h_mix;
  logic [31:0]                 prod;

  // four restoring reduction steps: r = (16*r + nib) mod HASH_SLOTS
  function automatic logic [SLW-1:0] mod4(input logic [SLW-1:0] r, input logic [3:0] nib);
    logic [SLW-1:0] acc;
    logic [SLW:0]   t;
    acc = r;
    for (int k = 3; k >= 0; k--) begin
      t = {acc, nib[k]};
      if (t >= NSL) begin
        t = t - NSL;
      end
      acc = t[SLW-1:0];
    end
    return acc;
  endfunction

  // byte stream: family byte, port big-endian, address big-endian, left aligned
  assign pack = key[144] ? {7'b0, 1'b1, key[143:0]}
                         : {7'b0, 1'b0, key[143:128], key[31:0], 96'b0};

  assign h_mix = h_r ^ {24'b0, sh_r[sat_pkg::PACK_W-1 -: 8]};
  assign prod  = h_mix * sat_pkg::FNV_PRIME;

  assign busy = (state_r != H_IDLE);
  assign hash = h_r;
  assign slot = m_r;

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      case (state_r)
        H_IDLE: begin
          if (start) begin
            sh_r    <= pack;
            cnt_r   <= key[144] ? 5'd19 : 5'd7;
            h_r     <= sat_pkg::FNV_OFFSET;
            state_r <= H_BYTE;
          end
        end
        H_BYTE: begin
          h_r   <= prod;
          mq_r  <= prod;
          sh_r  <= sh_r << 8;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            m_r     <= '0;
            mcnt_r  <= '0;
            state_r <= H_MOD;
          end
        end
        H_MOD: begin
          m_r    <= mod4(m_r, mq_r[31:28]);
          mq_r   <= mq_r << 4;
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd7) begin
            state_r <= H_IDLE;
          end
        end
        default: begin
          state_r <= H_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sat_datapath.sv =====
// sat_datapath.sv: key registers, session and slot memories, probe and scan counters.
// Depends on sat_pkg, sat_ram and sat_hash; driven by sat_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module sat_datapath #(
  parameter int MAX_SESSIONS = 256,
  parameter int HASH_SLOTS   = 512
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [1:0]      in_operation,
  input  wire logic [7:0]      in_target_session,
  input  wire logic            in_addr_is_v6,
  input  wire logic [63:0]     in_ip_high,
  input  wire logic [63:0]     in_ip_low,
  input  wire logic [15:0]     in_port,
  input  wire sat_pkg::cmd_t   cmd,
  output sat_pkg::stat_t       st,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [7:0]           out_session_number
);

  localparam int SW     = $clog2(MAX_SESSIONS);
  localparam int UW     = $clog2(MAX_SESSIONS + 1);
  localparam int SLW    = $clog2(HASH_SLOTS);
  localparam int CW     = (UW > 8) ? UW : 8;
  localparam int SLOT_W = SW + 34;

  logic [1:0]                 in_op_r;
  logic [7:0]                 in_tgt_r;
  logic [sat_pkg::KEY_W-1:0]  in_key_r;
  logic [sat_pkg::KEY_W-1:0]  wk_key_r;
  logic                       act_r;
  logic [SLW-1:0]             slot_r;
  logic [SLW-1:0]             n_r;
  logic [SLW-1:0]             first_del_r;
  logic                       have_del_r;
  logic [UW-1:0]              scan_r;
  logic [UW-1:0]              used_r;
  logic [SW-1:0]              sidx_r;
  logic                       out_valid_r;
  logic [2:0]                 out_status_r;
  logic [7:0]                 out_num_r;

  logic [sat_pkg::SESS_W-1:0] sess_rd;
  logic [sat_pkg::SESS_W-1:0] sess_wd;
  logic [SW-1:0]              sess_ra;
  logic [SLOT_W-1:0]          slot_rd;
  logic [SLOT_W-1:0]          slot_wd;
  logic [SLW-1:0]             slot_wa;
  logic [SW-1:0]              slot_sess;
  logic                       act_bit;
  logic                       hash_busy;
  logic [31:0]                hash;
  logic [SLW-1:0]             start_slot;
  logic [SLW-1:0]             slot_inc;
  logic [7:0]                 num_val;

  // hash unit
  sat_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.hash_start),
    .key   (wk_key_r),
    .busy  (hash_busy),
    .hash  (hash),
    .slot  (start_slot)
  );

  // session store: {active, key}
  always_comb begin
    case (cmd.sess_rd_sel)
      sat_pkg::SRD_SCAN: sess_ra = scan_r[SW-1:0];
      sat_pkg::SRD_SLOT: sess_ra = slot_sess;
      sat_pkg::SRD_TGT:  sess_ra = SW'(in_tgt_r);
      default:           sess_ra = scan_r[SW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.act_mode)
      sat_pkg::ACT_ONE:  act_bit = 1'b1;
      sat_pkg::ACT_ZERO: act_bit = 1'b0;
      sat_pkg::ACT_KEEP: act_bit = act_r;
      default:           act_bit = act_r;
    endcase
  end

  assign sess_wd = {act_bit, wk_key_r};

  sat_ram #(.WIDTH(sat_pkg::SESS_W), .DEPTH(MAX_SESSIONS)) u_sess_ram (
    .clk   (clk),
    .we    (cmd.sess_wr),
    .waddr (sidx_r),
    .wdata (sess_wd),
    .re    (cmd.sess_rd),
    .raddr (sess_ra),
    .rdata (sess_rd)
  );

  // slot store: {tag, hash, session}
  assign slot_wa   = cmd.slot_wr_first ? first_del_r : slot_r;
  assign slot_wd   = {cmd.slot_wr_tag, hash, sidx_r};
  assign slot_sess = slot_rd[SW-1:0];

  sat_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (cmd.slot_wr),
    .waddr (slot_wa),
    .wdata (slot_wd),
    .re    (cmd.slot_rd),
    .raddr (slot_r),
    .rdata (slot_rd)
  );

  assign slot_inc = (slot_r == SLW'(HASH_SLOTS - 1)) ? '0 : slot_r + 1'b1;

  // status toward the controller
  always_comb begin
    st.op           = sat_pkg::op_t'(in_op_r);
    st.tgt_ok       = CW'(in_tgt_r) < CW'(used_r);
    st.tag          = sat_pkg::tag_t'(slot_rd[SLOT_W-1 -: 2]);
    st.hash_eq      = (slot_rd[SW+31:SW] == hash);
    st.sess_eq      = sess_rd[sat_pkg::SESS_W-1] &&
                      (sess_rd[sat_pkg::KEY_W-1:0] == wk_key_r);
    st.slot_sess_ok = UW'(slot_sess) < used_r;
    st.have_del     = have_del_r;
    st.probe_last   = (n_r == SLW'(HASH_SLOTS - 1));
    st.scan_end     = (scan_r == used_r);
    st.used_full    = (used_r == UW'(MAX_SESSIONS));
    st.slot_last    = (slot_r == SLW'(HASH_SLOTS - 1));
    st.hash_busy    = hash_busy;
  end

  always_comb begin
    case (cmd.num_sel)
      sat_pkg::NUM_ZERO: num_val = 8'd0;
      sat_pkg::NUM_SLOT: num_val = 8'(slot_sess);
      sat_pkg::NUM_SCAN: num_val = 8'(scan_r);
      sat_pkg::NUM_SIDX: num_val = 8'(sidx_r);
      default:           num_val = 8'd0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      slot_r      <= '0;
      have_del_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.used_inc) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.probe_init) begin
        slot_r     <= start_slot;
        have_del_r <= 1'b0;
      end else if (cmd.advance) begin
        slot_r <= slot_inc;
      end
      if (cmd.note_del && !have_del_r) begin
        have_del_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_op_r  <= in_operation;
      in_tgt_r <= in_target_session;
      in_key_r <= {in_addr_is_v6, in_port,
                   in_addr_is_v6 ? in_ip_high : 64'd0,
                   in_addr_is_v6 ? in_ip_low : {32'd0, in_ip_low[31:0]}};
    end
    if (cmd.wk_load_in) begin
      wk_key_r <= in_key_r;
    end else if (cmd.wk_load_sess) begin
      wk_key_r <= sess_rd[sat_pkg::KEY_W-1:0];
      act_r    <= sess_rd[sat_pkg::SESS_W-1];
    end
    if (cmd.probe_init) begin
      n_r <= '0;
    end else if (cmd.advance) begin
      n_r <= n_r + 1'b1;
    end
    if (cmd.note_del && !have_del_r) begin
      first_del_r <= slot_r;
    end
    if (cmd.scan_init) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.sidx_tgt) begin
      sidx_r <= SW'(in_tgt_r);
    end else if (cmd.sidx_used) begin
      sidx_r <= used_r[SW-1:0];
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_num_r    <= num_val;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_session_number = out_num_r;

endmodule

`default_nettype wire

// ===== rtl/sat_ctrl.sv =====
// sat_ctrl.sv: controller state machine of the session address table.
// Depends on sat_pkg; issues commands to sat_datapath and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module sat_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire sat_pkg::stat_t st,
  output sat_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISP, S_SCAN_RD, S_SCAN_CHK, S_NEW, S_NEW_WR, S_TGT,
    S_HASH, S_HASH_W, S_PRD, S_PCHK, S_PSESS, S_RB_WR
  } state_t;

  // what the current probe is for
  typedef enum logic [1:0] {CTX_FIND, CTX_CREATE, CTX_UNIDX, CTX_REIDX} ctx_t;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;
  logic   ins;
  logic   p_hit;
  logic   p_fail;
  logic   p_first;

  assign busy = (state_r != S_IDLE);
  assign ins  = (ctx_r == CTX_CREATE) || (ctx_r == CTX_REIDX);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    p_hit     = 1'b0;
    p_fail    = 1'b0;
    p_first   = 1'b0;

    case (state_r)
      // mark every slot empty after reset
      S_CLR: begin
        cmd.slot_wr     = 1'b1;
        cmd.slot_wr_tag = sat_pkg::TAG_EMPTY;
        cmd.advance     = 1'b1;
        if (st.slot_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.wk_load_in = 1'b1;
        case (st.op)
          sat_pkg::OP_FIND: begin
            ctx_nxt   = CTX_FIND;
            state_nxt = S_HASH;
          end
          sat_pkg::OP_CREATE: begin
            cmd.scan_init = 1'b1;
            state_nxt     = S_SCAN_RD;
          end
          sat_pkg::OP_REMOVE, sat_pkg::OP_REBIND: begin
            if (!st.tgt_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = sat_pkg::ST_BAD;
              state_nxt       = S_IDLE;
            end else begin
              cmd.sess_rd     = 1'b1;
              cmd.sess_rd_sel = sat_pkg::SRD_TGT;
              cmd.sidx_tgt    = 1'b1;
              state_nxt       = S_TGT;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // linear scan of allocated sessions
      S_SCAN_RD: begin
        if (st.scan_end) begin
          state_nxt = S_NEW;
        end else begin
          cmd.sess_rd     = 1'b1;
          cmd.sess_rd_sel = sat_pkg::SRD_SCAN;
          state_nxt       = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (st.sess_eq) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = sat_pkg::ST_FOUND;
          cmd.num_sel     = sat_pkg::NUM_SCAN;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_NEW: begin
        if (st.used_full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = sat_pkg::ST_FULL;
          state_nxt       = S_IDLE;
        end else begin
          cmd.sidx_used = 1'b1;
          cmd.used_inc  = 1'b1;
          state_nxt     = S_NEW_WR;
        end
      end
      S_NEW_WR: begin
        cmd.sess_wr  = 1'b1;
        cmd.act_mode = sat_pkg::ACT_ONE;
        ctx_nxt      = CTX_CREATE;
        state_nxt    = S_HASH;
      end
      // old address of the target session
      S_TGT: begin
        cmd.wk_load_sess = 1'b1;
        ctx_nxt          = CTX_UNIDX;
        state_nxt        = S_HASH;
      end
      S_HASH: begin
        cmd.hash_start = 1'b1;
        state_nxt      = S_HASH_W;
      end
      S_HASH_W: begin
        if (!st.hash_busy) begin
          cmd.probe_init = 1'b1;
          state_nxt      = S_PRD;
        end
      end
      // probe loop: read slot, check tag, maybe check session
      S_PRD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_PCHK;
      end
      S_PCHK: begin
        case (st.tag)
          sat_pkg::TAG_EMPTY: begin
            if (ins) begin
              p_hit   = 1'b1;
              p_first = st.have_del;
            end else begin
              p_fail = 1'b1;
            end
          end
          sat_pkg::TAG_DELETED: begin
            if (st.probe_last && ins) begin
              p_hit   = 1'b1;
              p_first = st.have_del;
            end else if (st.probe_last) begin
              p_fail = 1'b1;
            end else begin
              cmd.note_del = 1'b1;
              cmd.advance  = 1'b1;
              state_nxt    = S_PRD;
            end
          end
          sat_pkg::TAG_USED: begin
            if (st.hash_eq) begin
              cmd.sess_rd     = 1'b1;
              cmd.sess_rd_sel = sat_pkg::SRD_SLOT;
              state_nxt       = S_PSESS;
            end else if (st.probe_last) begin
              p_hit   = ins && st.have_del;
              p_fail  = !(ins && st.have_del);
              p_first = 1'b1;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_PRD;
            end
          end
          default: begin
            if (st.probe_last) begin
              p_hit   = ins && st.have_del;
              p_fail  = !(ins && st.have_del);
              p_first = 1'b1;
            end else begin
              cmd.advance = 1'b1;
              state_nxt   = S_PRD;
            end
          end
        endcase
      end
      S_PSESS: begin
        if (st.sess_eq && st.slot_sess_ok) begin
          p_hit = 1'b1;
        end else if (st.probe_last) begin
          p_hit   = ins && st.have_del;
          p_fail  = !(ins && st.have_del);
          p_first = 1'b1;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_RB_WR: begin
        cmd.sess_wr  = 1'b1;
        cmd.act_mode = sat_pkg::ACT_KEEP;
        ctx_nxt      = CTX_REIDX;
        state_nxt    = S_HASH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // probe finished: act on the outcome
    if (p_hit || p_fail) begin
      state_nxt = S_IDLE;
      case (ctx_r)
        CTX_FIND: begin
          cmd.emit        = 1'b1;
          cmd.emit_status = p_hit ? sat_pkg::ST_FOUND : sat_pkg::ST_NOT_FOUND;
          cmd.num_sel     = p_hit ? sat_pkg::NUM_SLOT : sat_pkg::NUM_ZERO;
        end
        CTX_UNIDX: begin
          cmd.slot_wr       = p_hit;
          cmd.slot_wr_first = p_first;
          cmd.slot_wr_tag   = sat_pkg::TAG_DELETED;
          if (st.op == sat_pkg::OP_REMOVE) begin
            cmd.sess_wr     = 1'b1;
            cmd.act_mode    = sat_pkg::ACT_ZERO;
            cmd.emit        = 1'b1;
            cmd.emit_status = sat_pkg::ST_DONE;
          end else begin
            cmd.wk_load_in = 1'b1;
            state_nxt      = S_RB_WR;
          end
        end
        CTX_CREATE: begin
          cmd.slot_wr       = p_hit;
          cmd.slot_wr_first = p_first;
          cmd.slot_wr_tag   = sat_pkg::TAG_USED;
          cmd.emit          = 1'b1;
          cmd.emit_status   = p_hit ? sat_pkg::ST_CREATED : sat_pkg::ST_UNINDEXED;
          cmd.num_sel       = sat_pkg::NUM_SIDX;
        end
        CTX_REIDX: begin
          cmd.slot_wr       = p_hit;
          cmd.slot_wr_first = p_first;
          cmd.slot_wr_tag   = sat_pkg::TAG_USED;
          cmd.emit          = 1'b1;
          cmd.emit_status   = sat_pkg::ST_DONE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ctx_r   <= CTX_FIND;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/session_address_table.sv =====
// Session address table: peer sessions keyed by address, indexed by a linear-probe hash.
// After reset the block is busy while it marks every slot empty. Each probe pass first
// hashes the key's 7 or 19 bytes, then reads slots in turn; get-or-create first scans
// the allocated sessions. The session and slot memories each have one write port and
// one read port. One item at a time; the result strobe comes in the cycle after the
// last step and is not held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module session_address_table #(
  parameter int MAX_SESSIONS = 256,
  parameter int HASH_SLOTS   = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_target_session,
  input  wire logic        in_addr_is_v6,
  input  wire logic [63:0] in_ip_high,
  input  wire logic [63:0] in_ip_low,
  input  wire logic [15:0] in_port,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [7:0]       out_session_number
);

  sat_pkg::cmd_t  cmd;
  sat_pkg::stat_t st;

  // controller
  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // datapath
  sat_datapath #(
    .MAX_SESSIONS (MAX_SESSIONS),
    .HASH_SLOTS   (HASH_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_target_session  (in_target_session),
    .in_addr_is_v6      (in_addr_is_v6),
    .in_ip_high         (in_ip_high),
    .in_ip_low          (in_ip_low),
    .in_port            (in_port),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_session_number (out_session_number)
  );

endmodule

`default_nettype wire

// ===== rtl/sat_checker.sv =====
// sat_checker.sv: port-level checks of the session address table, bound to the top level.
// Depends on sat_pkg and session_address_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "session_address_table_defines.svh"

module sat_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_session_number
);

  // one result per item, never two in a row
  `SAT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held for two cycles")
  // an accepted item keeps the block busy
  `SAT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "not busy after accepting an item")
  // status codes stay in range
  `SAT_ASSERT_SAME(a_status_range, out_valid, out_status <= sat_pkg::ST_BAD, "status code out of range")
  // session number is zero unless a session was found or created
  `SAT_ASSERT_SAME(a_num_zero, out_valid && (out_status == sat_pkg::ST_NOT_FOUND || out_status == sat_pkg::ST_FULL || out_status == sat_pkg::ST_DONE || out_status == sat_pkg::ST_BAD), out_session_number == 8'd0, "session number not zero")

endmodule

bind session_address_table sat_checker u_sat_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_status         (out_status),
  .out_session_number (out_session_number)
);

`default_nettype wire
